// ===== rtl/wbps_pkg.sv =====
// Shared constants, command codes and cell control type for the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int ADDR_BITS   = 48;
  localparam int LEN_W       = 9;
  localparam int BYTE_W      = 8;
  localparam int GROUP_SIZE  = 16;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef struct packed {
    logic              shift;
    logic              rotate;
    logic              load;
    logic [BYTE_W-1:0] load_byte;
    logic              load_care;
  } cell_ctl_t;

endpackage

// ===== rtl/wbps_cell.sv =====
// One scanner cell: a window byte, a rotating pattern entry and its registered compare result.
module wbps_cell (
  input  logic                        clk,
  input  wbps_pkg::cell_ctl_t         ctl,
  input  logic                        sel,
  input  logic                        active,
  input  logic [wbps_pkg::BYTE_W-1:0] win_in,
  input  logic [wbps_pkg::BYTE_W-1:0] pat_in,
  input  logic                        care_in,
  output logic [wbps_pkg::BYTE_W-1:0] win_q,
  output logic [wbps_pkg::BYTE_W-1:0] pat_q,
  output logic                        care_q,
  output logic                        hit_q
);

  logic [wbps_pkg::BYTE_W-1:0] win_r;
  logic [wbps_pkg::BYTE_W-1:0] pat_r;
  logic                        care_r;
  logic                        hit_r;
  logic                        hit_nxt;

  assign hit_nxt = !active || !care_r || (win_in == pat_r);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= win_in;
      hit_r <= hit_nxt;
    end
    if (ctl.rotate) begin
      pat_r  <= pat_in;
      care_r <= care_in;
    end else if (ctl.load && sel) begin
      pat_r  <= ctl.load_byte;
      care_r <= ctl.load_care;
    end
  end

  assign win_q  = win_r;
  assign pat_q  = pat_r;
  assign care_q = care_r;
  assign hit_q  = hit_r;

endmodule

// ===== rtl/wildcard_byte_pattern_scan_core.sv =====
// Top level of the wildcard byte pattern scanner: cell row, match tree and output register.
// A data request's match passes stages s1 and s2 and the output register to out_valid.
// Throughput: one request per cycle unless in_stall; one cell-row shift per data byte.
// A pattern_length write that moves the pattern alignment rotates the pattern ring one
// step per cycle, holding off requests until the rotation is done.
// Synchronous active-low reset clears control state; pattern entries stay undefined.
module wildcard_byte_pattern_scan_core #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN,
  parameter int ADDR_BITS   = wbps_pkg::ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [7:0]                  in_entry_index,
  input  logic [wbps_pkg::BYTE_W-1:0] in_entry_byte,
  input  logic                        in_entry_care,
  input  logic [wbps_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [ADDR_BITS-1:0]        in_data_address,
  input  logic                        in_chunk_first,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ADDR_BITS-1:0]        out_match_address,
  input  logic                        cfg_we,
  input  logic [wbps_pkg::LEN_W-1:0]  cfg_wdata
);

  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam int CW = ((IW > wbps_pkg::LEN_W) ? IW : wbps_pkg::LEN_W) + 2;
  localparam int G  = wbps_pkg::GROUP_SIZE;
  localparam int NG = (MAX_PATTERN + G - 1) / G;

  logic [IW-1:0]        len_m1_r, len_m1_nxt;
  logic [IW-1:0]        rot_cnt_r, rot_cnt_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic                 found_r, found_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s2_valid_r, s2_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 s1_restart_r, s1_elig_r;
  logic                 s2_restart_r, s2_elig_r;
  logic [ADDR_BITS-1:0] s1_addr_r, s2_addr_r, out_addr_r;
  logic [NG-1:0]        s2_grp_r;

  logic                 adv, rotating, acc, produce;
  logic                 is_load, is_data, is_restart;
  logic                 idx_ok;
  logic [CW-1:0]        idx_w, len_w, tgt_w;
  logic [IW-1:0]        load_tgt;
  logic [FW-1:0]        fill_base, fill_upd;
  logic                 elig;
  logic [CW-1:0]        cfg_w, new_w, delta_w, sum_w;
  wbps_pkg::cell_ctl_t  ctl;

  logic [wbps_pkg::BYTE_W-1:0] win_q  [MAX_PATTERN];
  logic [wbps_pkg::BYTE_W-1:0] pat_q  [MAX_PATTERN];
  logic                        care_q [MAX_PATTERN];
  logic [NG*G-1:0]             hit_pad;
  logic [NG-1:0]               grp_and;

  assign adv      = !out_valid_r || !out_stall;
  assign rotating = (rot_cnt_r != '0);
  assign in_stall = !adv || rotating;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    is_load    = 1'b0;
    is_data    = 1'b0;
    is_restart = 1'b0;
    unique case (in_cmd)
      wbps_pkg::CMD_LOAD:    is_load    = 1'b1;
      wbps_pkg::CMD_DATA:    is_data    = 1'b1;
      wbps_pkg::CMD_RESTART: is_restart = 1'b1;
      default: ;
    endcase
  end

  // map pattern position to its ring slot
  always_comb begin
    idx_w  = CW'(in_entry_index);
    len_w  = CW'(len_m1_r);
    idx_ok = idx_w < CW'(MAX_PATTERN);
    if (idx_w <= len_w) begin
      tgt_w = len_w - idx_w;
    end else begin
      tgt_w = len_w + CW'(MAX_PATTERN) - idx_w;
    end
    load_tgt = tgt_w[IW-1:0];
  end

  always_comb begin
    ctl.shift     = acc && is_data;
    ctl.rotate    = rotating;
    ctl.load      = acc && is_load && idx_ok;
    ctl.load_byte = in_entry_byte;
    ctl.load_care = in_entry_care;
  end

  always_comb begin
    fill_base = in_chunk_first ? '0 : fill_r;
    fill_upd  = (CW'(fill_base) < CW'(MAX_PATTERN)) ? fill_base + FW'(1) : fill_base;
    elig      = CW'(fill_upd) > CW'(len_m1_r);
  end

  // length register and pending ring rotation
  always_comb begin
    cfg_w = CW'(cfg_wdata);
    if (cfg_w == '0) begin
      new_w = '0;
    end else if (cfg_w > CW'(MAX_PATTERN)) begin
      new_w = CW'(MAX_PATTERN - 1);
    end else begin
      new_w = cfg_w - CW'(1);
    end
    if (len_w >= new_w) begin
      delta_w = len_w - new_w;
    end else begin
      delta_w = len_w + CW'(MAX_PATTERN) - new_w;
    end
    sum_w = CW'(rot_cnt_r) - CW'(rotating) + (cfg_we ? delta_w : '0);
    if (sum_w >= CW'(MAX_PATTERN)) begin
      sum_w = sum_w - CW'(MAX_PATTERN);
    end
    rot_cnt_nxt = sum_w[IW-1:0];
    len_m1_nxt  = cfg_we ? new_w[IW-1:0] : len_m1_r;
  end

  genvar i;
  generate
    for (i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic [wbps_pkg::BYTE_W-1:0] win_in;
      logic                        hit;
      if (i == 0) begin : g_head
        assign win_in = in_data_byte;
      end else begin : g_link
        assign win_in = win_q[i-1];
      end
      wbps_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .sel     (load_tgt == IW'(i)),
        .active  (IW'(i) <= len_m1_r),
        .win_in  (win_in),
        .pat_in  (pat_q[(i + 1) % MAX_PATTERN]),
        .care_in (care_q[(i + 1) % MAX_PATTERN]),
        .win_q   (win_q[i]),
        .pat_q   (pat_q[i]),
        .care_q  (care_q[i]),
        .hit_q   (hit)
      );
      assign hit_pad[i] = hit;
    end
    for (i = MAX_PATTERN; i < NG * G; i++) begin : g_pad
      assign hit_pad[i] = 1'b1;
    end
    for (i = 0; i < NG; i++) begin : g_grp
      assign grp_and[i] = &hit_pad[i*G +: G];
    end
  endgenerate

  always_comb begin
    produce = adv && s2_valid_r && !s2_restart_r && s2_elig_r && (&s2_grp_r) && !found_r;

    s1_valid_nxt = adv ? (acc && (is_data || is_restart)) : s1_valid_r;
    s2_valid_nxt = adv ? s1_valid_r : s2_valid_r;

    found_nxt = found_r;
    if (adv && s2_valid_r && s2_restart_r) begin
      found_nxt = 1'b0;
    end else if (produce) begin
      found_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    fill_nxt = fill_r;
    if (acc && is_restart) begin
      fill_nxt = '0;
    end else if (acc && is_data) begin
      fill_nxt = fill_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r    <= '0;
      rot_cnt_r   <= '0;
      fill_r      <= '0;
      found_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_m1_r    <= len_m1_nxt;
      rot_cnt_r   <= rot_cnt_nxt;
      fill_r      <= fill_nxt;
      found_r     <= found_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_restart_r <= is_restart;
      s1_elig_r    <= elig;
      s1_addr_r    <= in_data_address - ADDR_BITS'(len_m1_r);
      s2_restart_r <= s1_restart_r;
      s2_elig_r    <= s1_elig_r;
      s2_addr_r    <= s1_addr_r;
      s2_grp_r     <= grp_and;
    end
    if (produce) begin
      out_addr_r <= s2_addr_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_address = out_addr_r;

endmodule

// ===== rtl/wbps_checker.sv =====
// Port-level checker for the wildcard byte pattern scanner, bound to the top level.
module wbps_checker #(
  parameter int ADDR_BITS = wbps_pkg::ADDR_BITS
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [1:0]           in_cmd,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ADDR_BITS-1:0] out_match_address
);

  logic data_seen_r, data_seen_nxt;

  assign data_seen_nxt = data_seen_r ||
                         (in_valid && !in_stall && (in_cmd == wbps_pkg::CMD_DATA));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_seen_r <= 1'b0;
    end else begin
      data_seen_r <= data_seen_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_address))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result is stalled");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> data_seen_r)
    else $error("result without any data request");

endmodule

bind wildcard_byte_pattern_scan_core wbps_checker #(.ADDR_BITS(ADDR_BITS)) u_wbps_checker (.*);

// ===== bench/wildcard_byte_pattern_scan_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wildcard byte pattern scanner: directed table, a stalled flood, then random phases.
module wildcard_byte_pattern_scan_core_tb;

  localparam int AW = wbps_pkg::ADDR_BITS;
  localparam int MP = wbps_pkg::MAX_PATTERN;
  localparam int LW = wbps_pkg::LEN_W;
  localparam int BW = wbps_pkg::BYTE_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 200;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_HIT} exp_kind_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [7:0]    index;
    logic [7:0]    entry;
    logic          care;
    logic [7:0]    data;
    logic [AW-1:0] addr;
    logic          first;
  } scan_req_t;

  typedef struct packed {
    scan_req_t     req;
    exp_kind_t     kind;
    logic [AW-1:0] hit_addr;
  } directed_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_cmd;
  logic [7:0]          in_entry_index;
  logic [BW-1:0]       in_entry_byte;
  logic                in_entry_care;
  logic [BW-1:0]       in_data_byte;
  logic [AW-1:0]       in_data_address;
  logic                in_chunk_first;
  logic                out_valid;
  logic                out_stall;
  logic [AW-1:0]       out_match_address;
  logic                cfg_we;
  logic [LW-1:0]       cfg_wdata;

  logic [7:0]          pat_byte [MP];
  logic                pat_care [MP];
  bit                  pat_loaded [MP];
  logic [7:0]          scan_window [MP];
  int unsigned         chunk_fill;
  bit                  hit_latched;
  logic [LW-1:0]       length_reg;

  logic [AW-1:0]       match_addr_q [$];
  directed_row_t       directed_q [$];
  int                  fail_count;
  int                  requests_sent;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  bit                  hold_request;

  wildcard_byte_pattern_scan_core uut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [AW-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[AW-1:0];
  endfunction

  function automatic scan_req_t noise_req(input logic [1:0] cmd);
    scan_req_t r;
    r.cmd   = cmd;
    r.index = 8'($urandom);
    r.entry = 8'($urandom);
    r.care  = 1'($urandom);
    r.data  = 8'($urandom);
    r.addr  = rand_addr();
    r.first = 1'($urandom);
    return r;
  endfunction

  function automatic int unsigned active_span();
    if (length_reg == 0) return 1;
    if (length_reg > MP) return MP;
    return length_reg;
  endfunction

  function automatic void clear_scan();
    foreach (scan_window[k]) scan_window[k] = '0;
    chunk_fill  = 0;
    hit_latched = 1'b0;
  endfunction

  function automatic bit predict_match(input scan_req_t r, output logic [AW-1:0] start);
    int unsigned span;
    int k;
    logic [AW-1:0] back;
    start = '0;
    if (r.cmd == wbps_pkg::CMD_LOAD) begin
      pat_byte[r.index]   = r.entry;
      pat_care[r.index]   = r.care;
      pat_loaded[r.index] = 1'b1;
      return 1'b0;
    end
    if (r.cmd == wbps_pkg::CMD_RESTART) begin
      clear_scan();
      return 1'b0;
    end
    if (r.cmd != wbps_pkg::CMD_DATA) return 1'b0;
    if (r.first) chunk_fill = 0;
    for (k = MP - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
    scan_window[0] = r.data;
    if (chunk_fill < MP) chunk_fill++;
    span = active_span();
    if (hit_latched || chunk_fill < span) return 1'b0;
    for (k = 0; k < span; k++) begin
      if (pat_care[k] && scan_window[span - 1 - k] != pat_byte[k]) return 1'b0;
    end
    hit_latched = 1'b1;
    back = AW'(span - 1);
    start = r.addr - back;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [1:0] cmd, input logic [7:0] index,
                                  input logic [7:0] entry, input logic care,
                                  input logic [7:0] data, input logic [AW-1:0] addr,
                                  input logic first, input exp_kind_t kind,
                                  input logic [AW-1:0] hit_addr);
    directed_row_t row;
    row.req.cmd   = cmd;
    row.req.index = index;
    row.req.entry = entry;
    row.req.care  = care;
    row.req.data  = data;
    row.req.addr  = addr;
    row.req.first = first;
    row.kind      = kind;
    row.hit_addr  = hit_addr;
    directed_q.push_back(row);
  endfunction

  task automatic issue(input scan_req_t r, input exp_kind_t kind, input logic [AW-1:0] typed);
    logic [AW-1:0] start;
    bit hit;
    int gap;
    in_valid        <= 1'b1;
    in_cmd          <= r.cmd;
    in_entry_index  <= r.index;
    in_entry_byte   <= r.entry;
    in_entry_care   <= r.care;
    in_data_byte    <= r.data;
    in_data_address <= r.addr;
    in_chunk_first  <= r.first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = predict_match(r, start);
    unique case (kind)
      EXP_MODEL: if (hit) match_addr_q.push_back(start);
      EXP_HIT: match_addr_q.push_back(typed);
      default: ;
    endcase
    if (r.cmd != CMD_UNUSED) requests_sent++;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_length(input logic [LW-1:0] value);
    in_valid <= 1'b0;
    while (match_addr_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    length_reg = value;
  endtask

  task automatic load_pattern(input int span, input int care_pct);
    scan_req_t r;
    int k;
    for (k = 0; k < span; k++) begin
      r = noise_req(wbps_pkg::CMD_LOAD);
      r.index = 8'(k);
      r.care = ($urandom_range(99) < care_pct);
      issue(r, EXP_MODEL, '0);
    end
  endtask

  task automatic scan_chunk(input int span, input bit with_pattern);
    scan_req_t r;
    logic [AW-1:0] next_addr;
    int lead, trail, body, spoil, split, k, j;
    lead  = $urandom_range(4, 0);
    trail = $urandom_range(3, 0);
    body  = with_pattern ? span : $urandom_range(20, 3);
    spoil = ($urandom_range(4) == 0) ? $urandom_range(span - 1, 0) : -1;
    split = ($urandom_range(9) == 0 && span > 1) ? $urandom_range(span - 1, 1) : -1;
    case ($urandom_range(3))
      0: next_addr = '0;
      1: next_addr = '1 - AW'($urandom_range(8));
      default: next_addr = rand_addr();
    endcase
    for (k = 0; k < lead + body + trail; k++) begin
      if ($urandom_range(29) == 0) issue(noise_req(CMD_UNUSED), EXP_MODEL, '0);
      if ($urandom_range(29) == 0) issue(noise_req(wbps_pkg::CMD_LOAD), EXP_MODEL, '0);
      r = noise_req(wbps_pkg::CMD_DATA);
      r.first = (k == 0) ? ($urandom_range(9) != 0) : 1'b0;
      if (with_pattern && k >= lead && k < lead + span) begin
        j = k - lead;
        if (pat_care[j]) r.data = pat_byte[j];
        if (j == spoil) r.data = r.data ^ 8'($urandom_range(255, 1));
        if (j == split) r.first = 1'b1;
      end
      if ($urandom_range(9) != 0) r.addr = next_addr;
      next_addr = next_addr + 1'b1;
      issue(r, EXP_MODEL, '0);
    end
  endtask

  task automatic run_phase(input logic [LW-1:0] value);
    int span, k;
    bit loaded;
    tx_idle_pct = $urandom_range(1) ? 30 : 0;
    rx_idle_pct = $urandom_range(1) ? 30 : 0;
    write_length(value);
    span = active_span();
    loaded = 1'b1;
    for (k = 0; k < span; k++) if (!pat_loaded[k]) loaded = 1'b0;
    if (span <= 32) begin
      load_pattern(span, 75);
      for (k = 0; k < 5; k++) begin
        if ($urandom_range(9) < 8) issue(noise_req(wbps_pkg::CMD_RESTART), EXP_MODEL, '0);
        scan_chunk(span, 1'b1);
      end
    end else if (!loaded) begin
      load_pattern(span, 25);
      issue(noise_req(wbps_pkg::CMD_RESTART), EXP_MODEL, '0);
      scan_chunk(span, 1'b1);
    end else begin
      for (k = 0; k < 3; k++) begin
        issue(noise_req(wbps_pkg::CMD_RESTART), EXP_MODEL, '0);
        scan_chunk(span, 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int phase_len [7];
    scan_req_t r;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_cmd          <= '0;
    in_entry_index  <= '0;
    in_entry_byte   <= '0;
    in_entry_care   <= 1'b0;
    in_data_byte    <= '0;
    in_data_address <= '0;
    in_chunk_first  <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    length_reg      = 1;
    clear_scan();
    fail_count      = 0;
    requests_sent   = 0;
    tx_idle_pct     = 25;
    rx_idle_pct     = 25;
    hold_request    = 1'b0;
    phase_len       = '{2, 3, 256, 7, 511, 1, 4};

    add_row(wbps_pkg::CMD_LOAD,    8'd0,   8'hA5, 1'b1, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'hA5, 48'hFFFFFFFFFFFF, 1'b1,
            EXP_HIT, 48'hFFFFFFFFFFFF);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'hA5, 48'h5,            1'b0,
            EXP_NONE, '0);
    add_row(CMD_UNUSED,            8'hFF,  8'hFF, 1'b1, 8'hFF, 48'hFFFFFFFFFFFF, 1'b1,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_RESTART, 8'd0,   8'h00, 1'b0, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'hA5, 48'h0,            1'b0,
            EXP_HIT, 48'h0);
    add_row(wbps_pkg::CMD_LOAD,    8'd255, 8'hFF, 1'b1, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_LOAD,    8'd0,   8'h00, 1'b0, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_RESTART, 8'd0,   8'h00, 1'b0, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'h5A, 48'h000012345678, 1'b1,
            EXP_HIT, 48'h000012345678);
    add_row(wbps_pkg::CMD_LOAD,    8'd0,   8'hFF, 1'b1, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_RESTART, 8'd0,   8'h00, 1'b0, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'h00, 48'h1,            1'b1,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'hFF, 48'h2,            1'b0,
            EXP_HIT, 48'h2);
    add_row(wbps_pkg::CMD_RESTART, 8'd0,   8'h00, 1'b0, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'h00, 48'h3,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_LOAD,    8'd0,   8'h00, 1'b1, 8'h00, 48'h0,            1'b0,
            EXP_NONE, '0);
    add_row(wbps_pkg::CMD_DATA,    8'd0,   8'h00, 1'b0, 8'h00, 48'h4,            1'b0,
            EXP_HIT, 48'h4);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) issue(directed_q[i].req, directed_q[i].kind, directed_q[i].hit_addr);

    // flood with one-byte wildcard matches while the result side holds off
    write_length('0);
    r = noise_req(wbps_pkg::CMD_LOAD);
    r.index = 8'd0;
    r.care = 1'b0;
    issue(r, EXP_MODEL, '0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    repeat (60) begin
      issue(noise_req(wbps_pkg::CMD_RESTART), EXP_MODEL, '0);
      issue(noise_req(wbps_pkg::CMD_DATA), EXP_MODEL, '0);
    end

    foreach (phase_len[i]) run_phase(LW'(phase_len[i]));
    while (requests_sent < 900) run_phase(LW'($urandom_range(20, 1)));

    in_valid <= 1'b0;
    while (match_addr_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("wildcard_byte_pattern_scan_core test passed");
    end else begin
      $display("wildcard_byte_pattern_scan_core test failed");
    end
    $finish;
  end

  initial begin : receiver
    int stall_left;
    int g;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        g = pick_gap(rx_idle_pct);
        stall_left = (g > 0) ? g - 1 : 0;
        out_stall <= (g > 0);
      end
    end
  end

  always @(posedge clk) begin : check_matches
    logic [AW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (match_addr_q.size() == 0) begin
        $error("match_address: expected none, got %h", out_match_address);
        fail_count++;
      end else begin
        want = match_addr_q.pop_front();
        if (out_match_address !== want) begin
          $error("match_address: expected %h, got %h", want, out_match_address);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("wildcard_byte_pattern_scan_core test failed");
    $finish;
  end

endmodule
